[src/euler_rotation_matrix_defines.svh]
// assertion macros shared by the rotation matrix block
`ifndef EULER_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ROTATION_MATRIX_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EUL_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define EUL_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error(msg);

`endif

[src/eul_pkg.sv]
package eul_pkg;

    // number formats
    localparam int FRAC_BITS        = 14;
    localparam int ONE_FX           = 1 << FRAC_BITS;
    localparam int HALF_LSB         = 1 << (FRAC_BITS - 1);
    localparam int ANGLE_W          = 16;
    localparam int COEF_W           = 16;
    localparam int ACC_W            = 32;

    // angle constants
    localparam int DEGREES_PER_TURN = 360;
    localparam int HALF_TURN        = 180;
    localparam int QUARTER_TURN     = DEGREES_PER_TURN / 4;
    localparam int DEG_W            = 9;

    // modulo reduction: bias to a positive value, then multiply by a reciprocal
    localparam int RED_OFFSET       = 92 * DEGREES_PER_TURN;
    localparam int U_W              = ANGLE_W + 1;
    localparam int RECIP_SHIFT      = 25;
    localparam int RECIP            = ((1 << RECIP_SHIFT) + DEGREES_PER_TURN - 1)
                                      / DEGREES_PER_TURN;
    localparam int MUL_W            = 2 * U_W;
    localparam int Q_W              = 8;

    // pipeline depth
    localparam int STAGES           = 7;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef                    t_mat [3][3];

    // quarter-wave sine, entry d = round(sin(d deg) * 2^14)
    localparam int LUT_N  = QUARTER_TURN + 1;
    localparam int LUT_IW = 7;
    localparam logic [COEF_W-2:0] SIN_LUT [LUT_N] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    // sine of a reduced angle 0..359 through quadrant folding
    function automatic t_coef sin_deg(input logic [DEG_W-1:0] r);
        logic [DEG_W-1:0]  k;
        logic              neg;
        logic [COEF_W-1:0] mag;
        priority if (r <= DEG_W'(QUARTER_TURN)) begin
            k   = r;
            neg = 1'b0;
        end else if (r <= DEG_W'(HALF_TURN)) begin
            k   = DEG_W'(HALF_TURN) - r;
            neg = 1'b0;
        end else if (r <= DEG_W'(HALF_TURN + QUARTER_TURN)) begin
            k   = r - DEG_W'(HALF_TURN);
            neg = 1'b1;
        end else begin
            k   = DEG_W'(DEGREES_PER_TURN) - r;
            neg = 1'b1;
        end
        mag = COEF_W'(SIN_LUT[k[LUT_IW-1:0]]);
        return t_coef'(neg ? -mag : mag);
    endfunction

    // round half up at the fraction point, then clamp to +-1.0
    function automatic t_coef round_clamp(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] q;
        t = s + ACC_W'(HALF_LSB);
        q = t >>> FRAC_BITS;
        if (q > ACC_W'(ONE_FX)) begin
            q = ACC_W'(ONE_FX);
        end else if (q < ACC_W'(-ONE_FX)) begin
            q = ACC_W'(-ONE_FX);
        end
        return COEF_W'(q);
    endfunction

endpackage

[src/eul_angle_reduce.sv]
module eul_angle_reduce (
    input  logic                                i_clk,
    input  logic [1:0]                          i_en,
    input  logic signed [eul_pkg::ANGLE_W-1:0]  i_angle,
    output logic [eul_pkg::DEG_W-1:0]           o_deg
);

    logic [eul_pkg::U_W-1:0]   n_u;
    logic [eul_pkg::MUL_W-1:0] n_prod;
    logic [eul_pkg::U_W-1:0]   r_u;
    logic [eul_pkg::Q_W-1:0]   r_q;
    logic [eul_pkg::U_W-1:0]   n_q360;
    logic [eul_pkg::DEG_W-1:0] r_deg;

    // bias into a positive range that is a whole number of turns, then estimate quotient
    assign n_u    = {i_angle[eul_pkg::ANGLE_W-1], i_angle} + eul_pkg::U_W'(eul_pkg::RED_OFFSET);
    assign n_prod = eul_pkg::MUL_W'(n_u) * eul_pkg::MUL_W'(eul_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_u <= n_u;
            r_q <= n_prod[eul_pkg::RECIP_SHIFT +: eul_pkg::Q_W];
        end
    end

    // remainder from the exact quotient
    assign n_q360 = eul_pkg::U_W'(r_q) * eul_pkg::U_W'(eul_pkg::DEGREES_PER_TURN);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_deg <= eul_pkg::DEG_W'(r_u - n_q360);
        end
    end

    assign o_deg = r_deg;

endmodule

[src/eul_sincos.sv]
module eul_sincos (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [eul_pkg::DEG_W-1:0]   i_deg,
    output eul_pkg::t_coef              o_sin,
    output eul_pkg::t_coef              o_cos
);

    logic [eul_pkg::DEG_W:0]   n_sum;
    logic [eul_pkg::DEG_W-1:0] n_cos_deg;
    eul_pkg::t_coef            r_sin;
    eul_pkg::t_coef            r_cos;

    // cosine is the sine a quarter turn ahead
    assign n_sum     = {1'b0, i_deg} + (eul_pkg::DEG_W + 1)'(eul_pkg::QUARTER_TURN);
    assign n_cos_deg = (n_sum >= (eul_pkg::DEG_W + 1)'(eul_pkg::DEGREES_PER_TURN))
                     ? eul_pkg::DEG_W'(n_sum - (eul_pkg::DEG_W + 1)'(eul_pkg::DEGREES_PER_TURN))
                     : n_sum[eul_pkg::DEG_W-1:0];

    // table lookups
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= eul_pkg::sin_deg(i_deg);
            r_cos <= eul_pkg::sin_deg(n_cos_deg);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

[src/eul_mat_inner.sv]
module eul_mat_inner (
    input  logic            i_clk,
    input  logic [1:0]      i_en,
    input  eul_pkg::t_coef  i_sx,
    input  eul_pkg::t_coef  i_cx,
    input  eul_pkg::t_coef  i_sy,
    input  eul_pkg::t_coef  i_cy,
    input  eul_pkg::t_coef  i_sz,
    input  eul_pkg::t_coef  i_cz,
    output eul_pkg::t_coef  o_sx,
    output eul_pkg::t_coef  o_cx,
    output eul_pkg::t_mat   o_t
);

    logic signed [eul_pkg::ACC_W-1:0] r_pcc;
    logic signed [eul_pkg::ACC_W-1:0] r_pcs;
    logic signed [eul_pkg::ACC_W-1:0] r_psc;
    logic signed [eul_pkg::ACC_W-1:0] r_pss;
    eul_pkg::t_coef                   r_sy;
    eul_pkg::t_coef                   r_cy;
    eul_pkg::t_coef                   r_sz;
    eul_pkg::t_coef                   r_cz;
    eul_pkg::t_coef                   r_sx1;
    eul_pkg::t_coef                   r_cx1;
    eul_pkg::t_coef                   r_sx2;
    eul_pkg::t_coef                   r_cx2;
    eul_pkg::t_mat                    n_t;
    eul_pkg::t_mat                    r_t;

    // products of the y and z factors
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pcc <= eul_pkg::ACC_W'(i_cy) * eul_pkg::ACC_W'(i_cz);
            r_pcs <= eul_pkg::ACC_W'(i_cy) * eul_pkg::ACC_W'(i_sz);
            r_psc <= eul_pkg::ACC_W'(i_sy) * eul_pkg::ACC_W'(i_cz);
            r_pss <= eul_pkg::ACC_W'(i_sy) * eul_pkg::ACC_W'(i_sz);
            r_sy  <= i_sy;
            r_cy  <= i_cy;
            r_sz  <= i_sz;
            r_cz  <= i_cz;
            r_sx1 <= i_sx;
            r_cx1 <= i_cx;
        end
    end

    // entries of Ry * Rz; unit and zero terms fall out exactly
    always_comb begin
        n_t[0][0] = eul_pkg::round_clamp(r_pcc);
        n_t[0][1] = eul_pkg::round_clamp(-r_pcs);
        n_t[0][2] = r_sy;
        n_t[1][0] = r_sz;
        n_t[1][1] = r_cz;
        n_t[1][2] = '0;
        n_t[2][0] = eul_pkg::round_clamp(-r_psc);
        n_t[2][1] = eul_pkg::round_clamp(r_pss);
        n_t[2][2] = r_cy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_t   <= n_t;
            r_sx2 <= r_sx1;
            r_cx2 <= r_cx1;
        end
    end

    assign o_t  = r_t;
    assign o_sx = r_sx2;
    assign o_cx = r_cx2;

endmodule

[src/eul_mat_outer.sv]
module eul_mat_outer (
    input  logic            i_clk,
    input  logic [1:0]      i_en,
    input  eul_pkg::t_coef  i_sx,
    input  eul_pkg::t_coef  i_cx,
    input  eul_pkg::t_mat   i_t,
    output eul_pkg::t_mat   o_m
);

    logic signed [eul_pkg::ACC_W-1:0] r_a1 [3];
    logic signed [eul_pkg::ACC_W-1:0] r_b1 [3];
    logic signed [eul_pkg::ACC_W-1:0] r_a2 [3];
    logic signed [eul_pkg::ACC_W-1:0] r_b2 [3];
    eul_pkg::t_coef                   r_row0 [3];
    eul_pkg::t_mat                    n_m;
    eul_pkg::t_mat                    r_m;

    // column products for rows two and three of Rx * T
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int j = 0; j < 3; j++) begin
                r_a1[j]   <= eul_pkg::ACC_W'(i_cx) * eul_pkg::ACC_W'(i_t[1][j]);
                r_b1[j]   <= eul_pkg::ACC_W'(i_sx) * eul_pkg::ACC_W'(i_t[2][j]);
                r_a2[j]   <= eul_pkg::ACC_W'(i_sx) * eul_pkg::ACC_W'(i_t[1][j]);
                r_b2[j]   <= eul_pkg::ACC_W'(i_cx) * eul_pkg::ACC_W'(i_t[2][j]);
                r_row0[j] <= i_t[0][j];
            end
        end
    end

    // sum, round and clamp; the first row passes unchanged
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_m[0][j] = r_row0[j];
            n_m[1][j] = eul_pkg::round_clamp(r_a1[j] - r_b1[j]);
            n_m[2][j] = eul_pkg::round_clamp(r_a2[j] + r_b2[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_m <= n_m;
        end
    end

    assign o_m = r_m;

endmodule

[src/euler_rotation_matrix.sv]
// x-y-z Euler angle rotation matrix, Q1.14 entries
// each accepted word passes in order through angle reduction, sine and cosine lookup, Ry * Rz and Rx * (Ry * Rz)
// throughput: one word per cycle; a stage holds only while the stage after it is full and blocked
// a stalled output lets the input keep filling empty stages behind it
// reset clears the stage valid bits only; data registers are left as they are
`include "euler_rotation_matrix_defines.svh"

module euler_rotation_matrix (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [eul_pkg::ANGLE_W-1:0]  i_angle_x,
    input  logic signed [eul_pkg::ANGLE_W-1:0]  i_angle_y,
    input  logic signed [eul_pkg::ANGLE_W-1:0]  i_angle_z,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [eul_pkg::COEF_W-1:0]   o_m11,
    output logic signed [eul_pkg::COEF_W-1:0]   o_m12,
    output logic signed [eul_pkg::COEF_W-1:0]   o_m13,
    output logic signed [eul_pkg::COEF_W-1:0]   o_m21,
    output logic signed [eul_pkg::COEF_W-1:0]   o_m22,
    output logic signed [eul_pkg::COEF_W-1:0]   o_m23,
    output logic signed [eul_pkg::COEF_W-1:0]   o_m31,
    output logic signed [eul_pkg::COEF_W-1:0]   o_m32,
    output logic signed [eul_pkg::COEF_W-1:0]   o_m33
);

    logic [eul_pkg::STAGES-1:0]   r_valid;
    logic [eul_pkg::STAGES-1:0]   n_valid;
    logic [eul_pkg::STAGES-1:0]   stage_en;
    logic [eul_pkg::DEG_W-1:0]    deg_x;
    logic [eul_pkg::DEG_W-1:0]    deg_y;
    logic [eul_pkg::DEG_W-1:0]    deg_z;
    eul_pkg::t_coef               sx;
    eul_pkg::t_coef               cx;
    eul_pkg::t_coef               sy;
    eul_pkg::t_coef               cy;
    eul_pkg::t_coef               sz;
    eul_pkg::t_coef               cz;
    eul_pkg::t_coef               sx_d;
    eul_pkg::t_coef               cx_d;
    eul_pkg::t_mat                t_inner;
    eul_pkg::t_mat                m_out;

    // a stage loads when it is empty or its contents move on
    assign stage_en[eul_pkg::STAGES-1] = !r_valid[eul_pkg::STAGES-1] || i_out_ready;
    for (genvar k = 0; k < eul_pkg::STAGES - 1; k++) begin : g_en
        assign stage_en[k] = !r_valid[k] || stage_en[k+1];
    end

    assign n_valid = {r_valid[eul_pkg::STAGES-2:0], i_in_valid};

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < eul_pkg::STAGES; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    assign o_in_ready  = stage_en[0];
    assign o_out_valid = r_valid[eul_pkg::STAGES-1];

    // angle reduction, stages 1 and 2
    eul_angle_reduce u_red_x (
        .i_clk   (i_clk),
        .i_en    (stage_en[1:0]),
        .i_angle (i_angle_x),
        .o_deg   (deg_x)
    );

    eul_angle_reduce u_red_y (
        .i_clk   (i_clk),
        .i_en    (stage_en[1:0]),
        .i_angle (i_angle_y),
        .o_deg   (deg_y)
    );

    eul_angle_reduce u_red_z (
        .i_clk   (i_clk),
        .i_en    (stage_en[1:0]),
        .i_angle (i_angle_z),
        .o_deg   (deg_z)
    );

    // sine and cosine lookup, stage 3
    eul_sincos u_sc_x (
        .i_clk (i_clk),
        .i_en  (stage_en[2]),
        .i_deg (deg_x),
        .o_sin (sx),
        .o_cos (cx)
    );

    eul_sincos u_sc_y (
        .i_clk (i_clk),
        .i_en  (stage_en[2]),
        .i_deg (deg_y),
        .o_sin (sy),
        .o_cos (cy)
    );

    eul_sincos u_sc_z (
        .i_clk (i_clk),
        .i_en  (stage_en[2]),
        .i_deg (deg_z),
        .o_sin (sz),
        .o_cos (cz)
    );

    // Ry * Rz, stages 4 and 5
    eul_mat_inner u_inner (
        .i_clk (i_clk),
        .i_en  (stage_en[4:3]),
        .i_sx  (sx),
        .i_cx  (cx),
        .i_sy  (sy),
        .i_cy  (cy),
        .i_sz  (sz),
        .i_cz  (cz),
        .o_sx  (sx_d),
        .o_cx  (cx_d),
        .o_t   (t_inner)
    );

    // Rx * (Ry * Rz), stages 6 and 7
    eul_mat_outer u_outer (
        .i_clk (i_clk),
        .i_en  (stage_en[6:5]),
        .i_sx  (sx_d),
        .i_cx  (cx_d),
        .i_t   (t_inner),
        .o_m   (m_out)
    );

    assign o_m11 = m_out[0][0];
    assign o_m12 = m_out[0][1];
    assign o_m13 = m_out[0][2];
    assign o_m21 = m_out[1][0];
    assign o_m22 = m_out[1][1];
    assign o_m23 = m_out[1][2];
    assign o_m31 = m_out[2][0];
    assign o_m32 = m_out[2][1];
    assign o_m33 = m_out[2][2];

    // an empty output stage never blocks the input
    `EUL_ASSERT_NOW(a_ready_when_drained, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input blocked with output stage empty")

    // a word taken into an empty pipe lands in the first stage
    `EUL_ASSERT_NEXT(a_fill_first_stage, i_clk, i_rst_n, (r_valid == '0) && i_in_valid, r_valid[0], "accepted word missing from first stage")

    // diagonal entries stay within +-1.0
    `EUL_ASSERT_NOW(a_diag_range, i_clk, i_rst_n, o_out_valid, (o_m11 <= 16'sd16384) && (o_m11 >= -16'sd16384) && (o_m22 <= 16'sd16384) && (o_m22 >= -16'sd16384) && (o_m33 <= 16'sd16384) && (o_m33 >= -16'sd16384), "diagonal entry out of range")

endmodule

[verif/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     ANGLE_W      = eul_pkg::ANGLE_W;
    localparam int     COEF_W       = eul_pkg::COEF_W;
    localparam int     RESET_CYCLES = 2;
    localparam int     SETTLE_WAIT  = 12;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam longint Q14_ONE      = 64'sd16384;
    localparam longint Q14_HALF     = 64'sd8192;
    localparam int     TURN_DEG     = 360;
    localparam int     HALF_DEG     = 180;
    localparam int     QUARTER_DEG  = 90;

    typedef logic [8:0][COEF_W-1:0] t_rot_word;
    typedef longint                 t_lmat [3][3];

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [ANGLE_W-1:0] i_angle_x = '0;
    logic signed [ANGLE_W-1:0] i_angle_y = '0;
    logic signed [ANGLE_W-1:0] i_angle_z = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [COEF_W-1:0]  o_m11, o_m12, o_m13;
    logic signed [COEF_W-1:0]  o_m21, o_m22, o_m23;
    logic signed [COEF_W-1:0]  o_m31, o_m32, o_m33;

    // expected matrices in arrival order and the sine table in q1.14
    t_rot_word matrix_q [$];
    longint    sine_q14 [0:90];
    string     entry_name [9] = '{"m11", "m12", "m13", "m21", "m22", "m23",
                                  "m31", "m32", "m33"};
    int        mismatches = 0;
    int        cycle_count = 0;

    // sender burst and receiver stall controls
    int        gap_max = 0;
    int        burst_max = 1;
    int        burst_left = 0;
    int        stall_max = 0;
    int        ready_max = 1;
    int        hold_left = 0;

    euler_rotation_matrix u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_angle_x   (i_angle_x),
        .i_angle_y   (i_angle_y),
        .i_angle_z   (i_angle_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_m11       (o_m11),
        .o_m12       (o_m12),
        .o_m13       (o_m13),
        .o_m21       (o_m21),
        .o_m22       (o_m22),
        .o_m23       (o_m23),
        .o_m31       (o_m31),
        .o_m32       (o_m32),
        .o_m33       (o_m33)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // 64 bits of a q2.62 product taken from bit 62 up, as (a * b) >> 62
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // quarter-wave sine from a taylor series in q2.62, rounded half up to q1.14
    initial begin : sine_table_init
        logic [63:0] pi_q62;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        pi_q62 = 64'hC90FDAA22168C235;
        for (int d = 0; d <= QUARTER_DEG; d++) begin
            x = (pi_q62 / 64'd180) * 64'(d) + ((pi_q62 % 64'd180) * 64'(d)) / 64'd180;
            x2 = mul_q62(x, x);
            term = x;
            sum = x;
            for (int n = 1; n <= 13; n++) begin
                term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            sine_q14[d] = longint'((sum + (64'd1 << 47)) >> 48);
        end
    end

    // angle in whole degrees folded into 0..359
    function automatic int wrap_degrees(input logic signed [ANGLE_W-1:0] a);
        int r;
        r = int'(a) % TURN_DEG;
        if (r < 0) begin
            r = r + TURN_DEG;
        end
        return r;
    endfunction

    // sine of a folded angle through quadrant symmetry
    function automatic longint sine_of(input int r);
        if (r <= QUARTER_DEG) begin
            return sine_q14[r];
        end else if (r <= HALF_DEG) begin
            return sine_q14[HALF_DEG - r];
        end else if (r <= HALF_DEG + QUARTER_DEG) begin
            return -sine_q14[r - HALF_DEG];
        end
        return -sine_q14[TURN_DEG - r];
    endfunction

    // floor of (sum + half lsb) at the fraction point, clamped to +-1.0
    function automatic longint round_q14(input longint s);
        longint q;
        q = (s + Q14_HALF) >>> 14;
        if (q > Q14_ONE) begin
            q = Q14_ONE;
        end else if (q < -Q14_ONE) begin
            q = -Q14_ONE;
        end
        return q;
    endfunction

    function automatic t_lmat mat_product(input t_lmat a, input t_lmat b);
        t_lmat r;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r[i][j] = round_q14(a[i][0] * b[0][j] + a[i][1] * b[1][j]
                                    + a[i][2] * b[2][j]);
            end
        end
        return r;
    endfunction

    // expected matrix R = Rx * (Ry * Rz) for one angle triple
    function automatic t_rot_word predict_rotation(input logic signed [ANGLE_W-1:0] ax,
                                                   input logic signed [ANGLE_W-1:0] ay,
                                                   input logic signed [ANGLE_W-1:0] az);
        t_lmat     rx, ry, rz, inner, full;
        longint    sx, cx, sy, cy, sz, cz;
        int        dx, dy, dz;
        t_rot_word w;
        dx = wrap_degrees(ax);
        dy = wrap_degrees(ay);
        dz = wrap_degrees(az);
        sx = sine_of(dx);
        cx = sine_of((dx + QUARTER_DEG) % TURN_DEG);
        sy = sine_of(dy);
        cy = sine_of((dy + QUARTER_DEG) % TURN_DEG);
        sz = sine_of(dz);
        cz = sine_of((dz + QUARTER_DEG) % TURN_DEG);
        rx = '{'{Q14_ONE, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
        ry = '{'{cy, 0, sy}, '{0, Q14_ONE, 0}, '{-sy, 0, cy}};
        rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, Q14_ONE}};
        inner = mat_product(ry, rz);
        full = mat_product(rx, inner);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w[i * 3 + j] = full[i][j][COEF_W-1:0];
            end
        end
        return w;
    endfunction

    // output word check first, then predict the input word taken at this edge
    always @(posedge i_clk) begin
        t_rot_word got;
        t_rot_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_m33, o_m32, o_m31, o_m23, o_m22, o_m21, o_m13, o_m12, o_m11};
            if (matrix_q.size() == 0) begin
                mismatches++;
                $display("%0t: expected no output word, actual %h", $time, got);
            end else begin
                want = matrix_q.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (got[k] !== want[k]) begin
                        mismatches++;
                        $display("%0t: %s expected %0d actual %0d", $time, entry_name[k],
                                 $signed(want[k]), $signed(got[k]));
                    end
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            matrix_q.push_back(predict_rotation(i_angle_x, i_angle_y, i_angle_z));
        end
    end

    // receiver: ready runs and stall runs of random length
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
        end else if (i_out_ready && stall_max != 0) begin
            i_out_ready <= 1'b0;
            hold_left = $urandom_range(stall_max - 1, 0);
        end else begin
            i_out_ready <= 1'b1;
            hold_left = $urandom_range(ready_max - 1, 0);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // one input word, with a random gap before each new burst
    task automatic send_angles(input logic [ANGLE_W-1:0] ax, input logic [ANGLE_W-1:0] ay,
                               input logic [ANGLE_W-1:0] az);
        int gap;
        if (gap_max != 0 && burst_left == 0) begin
            gap = $urandom_range(gap_max, 1);
            i_in_valid <= 1'b0;
            i_angle_x <= 16'($urandom);
            i_angle_y <= 16'($urandom);
            i_angle_z <= 16'($urandom);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(burst_max, 1);
        end
        if (burst_left != 0) begin
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_angle_x <= ax;
        i_angle_y <= ay;
        i_angle_z <= az;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending and wait for every expected matrix
    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (matrix_q.size() != 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // mix of full-range, near-zero, quadrant-edge and extreme angles
    function automatic logic [ANGLE_W-1:0] random_angle();
        int v;
        case ($urandom_range(5))
            1: v = int'($urandom_range(1440)) - 720;
            2: v = (int'($urandom_range(728)) - 364) * QUARTER_DEG
                   + int'($urandom_range(2)) - 1;
            3: begin
                case ($urandom_range(6))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    3: v = -1;
                    4: v = 1;
                    5: v = TURN_DEG;
                    default: v = -TURN_DEG;
                endcase
            end
            default: v = int'($urandom_range(65535)) - 32768;
        endcase
        return ANGLE_W'(v);
    endfunction

    task automatic send_random_words(input int count);
        for (int n = 0; n < count; n++) begin
            send_angles(random_angle(), random_angle(), random_angle());
        end
    endtask

    // zero, single axes, quadrant edges, wrap-around and field extremes
    task automatic test_directed_angles();
        int triples [21][3] = '{
            '{0, 0, 0}, '{90, 0, 0}, '{0, 90, 0}, '{0, 0, 90},
            '{-90, -90, -90}, '{180, 180, 180}, '{270, 45, 30}, '{359, 1, -1},
            '{360, -360, 720}, '{-32768, -32768, -32768}, '{32767, 32767, 32767},
            '{-32768, 32767, 0}, '{32767, -32768, -1}, '{45, 45, 45},
            '{30, 60, 89}, '{-180, 91, 179}, '{181, 269, 271}, '{-1, -1, -1},
            '{12345, -23456, 5}, '{21845, -21846, 21845}, '{-21846, 21845, -21846}
        };
        gap_max = 3;
        burst_max = 4;
        stall_max = 2;
        ready_max = 3;
        for (int n = 0; n < 21; n++) begin
            send_angles(ANGLE_W'(triples[n][0]), ANGLE_W'(triples[n][1]),
                        ANGLE_W'(triples[n][2]));
        end
        settle_pipeline();
    endtask

    // back-to-back words with the receiver always ready
    task automatic test_full_rate();
        gap_max = 0;
        stall_max = 0;
        ready_max = 1;
        send_random_words(300);
        settle_pipeline();
    endtask

    // bursts of words against short receiver stalls
    task automatic test_bursty_traffic();
        gap_max = 6;
        burst_max = 12;
        stall_max = 5;
        ready_max = 8;
        send_random_words(900);
        settle_pipeline();
    endtask

    // full-rate sender against long receiver stalls
    task automatic test_backpressure();
        gap_max = 0;
        stall_max = 30;
        ready_max = 3;
        send_random_words(330);
        settle_pipeline();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_angles();
        test_full_rate();
        test_bursty_traffic();
        test_backpressure();
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
